>>> rtl/stcf_pkg.sv
package stcf_pkg;

    localparam int unsigned REM_W   = 9;
    localparam int unsigned MONTH_W = 4;

    localparam logic [MONTH_W-1:0] MONTH_LAST = MONTH_W'(11);
    localparam logic [7:0]         YEAR_BASE  = 8'd70;

    typedef enum logic [2:0] {
        DIV_SEC,
        DIV_MIN,
        DIV_HOUR,
        DIV_WDAY,
        DIV_YEAR
    } t_div_sel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CAPTURE,
        ST_MONTH,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic     load;
        t_div_sel load_sel;
        logic     step;
        logic     capture;
        t_div_sel cur_sel;
        logic     month_step;
        logic     publish;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic month_done;
    } t_dp_status;

    function automatic logic [REM_W-1:0] divisor_of(input t_div_sel sel);
        logic [REM_W-1:0] d;
        case (sel)
            DIV_SEC:  d = REM_W'(60);
            DIV_MIN:  d = REM_W'(60);
            DIV_HOUR: d = REM_W'(24);
            DIV_WDAY: d = REM_W'(7);
            DIV_YEAR: d = REM_W'(365);
            default:  d = REM_W'(365);
        endcase
        return d;
    endfunction

    function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] mon);
        logic [4:0] len;
        case (mon)
            4'd0:    len = 5'd31;
            4'd1:    len = 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/stcf_in_if.sv
interface stcf_in_if #(
    parameter int unsigned SECONDS_WIDTH = 32
);
    logic                     valid;
    logic                     ready;
    logic [SECONDS_WIDTH-1:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

>>> rtl/stcf_out_if.sv
interface stcf_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [7:0] year_from_1900;
    logic [8:0] day_of_year;
    logic [3:0] month;
    logic [4:0] day_of_month;

    modport source (
        output valid, output second, output minute, output hour, output weekday,
        output year_from_1900, output day_of_year, output month, output day_of_month,
        input ready
    );
    modport sink (
        input valid, input second, input minute, input hour, input weekday,
        input year_from_1900, input day_of_year, input month, input day_of_month,
        output ready
    );
endinterface

>>> rtl/stcf_ctrl.sv
module stcf_ctrl
    import stcf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state   r_state, n_state;
    t_div_sel r_sel, n_sel;
    logic     r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sel       <= DIV_SEC;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_sel            = r_sel;
        o_in_ready       = 1'b0;
        o_cmd.load       = 1'b0;
        o_cmd.load_sel   = r_sel;
        o_cmd.step       = 1'b0;
        o_cmd.capture    = 1'b0;
        o_cmd.cur_sel    = r_sel;
        o_cmd.month_step = 1'b0;
        o_cmd.publish    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.load_sel = DIV_SEC;
                    n_sel          = DIV_SEC;
                    n_state        = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_CAPTURE;
                end
            end
            ST_CAPTURE: begin
                o_cmd.capture = 1'b1;
                n_state       = ST_DIV;
                o_cmd.load    = 1'b1;
                case (r_sel)
                    DIV_SEC: begin
                        o_cmd.load_sel = DIV_MIN;
                        n_sel          = DIV_MIN;
                    end
                    DIV_MIN: begin
                        o_cmd.load_sel = DIV_HOUR;
                        n_sel          = DIV_HOUR;
                    end
                    DIV_HOUR: begin
                        o_cmd.load_sel = DIV_WDAY;
                        n_sel          = DIV_WDAY;
                    end
                    DIV_WDAY: begin
                        o_cmd.load_sel = DIV_YEAR;
                        n_sel          = DIV_YEAR;
                    end
                    default: begin
                        o_cmd.load = 1'b0;
                        n_state    = ST_MONTH;
                    end
                endcase
            end
            ST_MONTH: begin
                if (i_status.month_done) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.month_step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/stcf_datapath.sv
module stcf_datapath
    import stcf_pkg::*;
#(
    parameter int unsigned SECONDS_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_status               o_status,
    input  logic [SECONDS_WIDTH-1:0] i_epoch_seconds,
    output logic [5:0]               o_second,
    output logic [5:0]               o_minute,
    output logic [4:0]               o_hour,
    output logic [2:0]               o_weekday,
    output logic [7:0]               o_year_from_1900,
    output logic [8:0]               o_day_of_year,
    output logic [3:0]               o_month,
    output logic [4:0]               o_day_of_month
);

    localparam int unsigned W         = SECONDS_WIDTH;
    localparam int unsigned CHUNK_W   = 16;
    localparam int unsigned SHIFT     = W + REM_W;
    localparam int unsigned NCHUNK    = (SHIFT + CHUNK_W - 1) / CHUNK_W;
    localparam int unsigned RECIP_PAD = NCHUNK * CHUNK_W;
    localparam int unsigned PROD_W    = W + RECIP_PAD;
    localparam int unsigned CNT_W     = $clog2(NCHUNK);

    // Scaled reciprocals, rounded up; exact for every dividend below 2**W.
    localparam logic [63:0]          SCALE     = 64'd1 << SHIFT;
    localparam logic [RECIP_PAD-1:0] RECIP_60  = RECIP_PAD'((SCALE + 64'd59) / 64'd60);
    localparam logic [RECIP_PAD-1:0] RECIP_24  = RECIP_PAD'((SCALE + 64'd23) / 64'd24);
    localparam logic [RECIP_PAD-1:0] RECIP_7   = RECIP_PAD'((SCALE + 64'd6) / 64'd7);
    localparam logic [RECIP_PAD-1:0] RECIP_365 = RECIP_PAD'((SCALE + 64'd364) / 64'd365);

    function automatic logic [RECIP_PAD-1:0] recip_of(input t_div_sel sel);
        logic [RECIP_PAD-1:0] m;
        case (sel)
            DIV_SEC:  m = RECIP_60;
            DIV_MIN:  m = RECIP_60;
            DIV_HOUR: m = RECIP_24;
            DIV_WDAY: m = RECIP_7;
            DIV_YEAR: m = RECIP_365;
            default:  m = RECIP_365;
        endcase
        return m;
    endfunction

    logic [W-1:0]         r_q;
    logic [RECIP_PAD-1:0] r_recip;
    logic [PROD_W-1:0]    r_acc;
    logic [CNT_W-1:0]     r_cnt;
    logic [W-1:0]         r_days;
    logic [5:0]           r_sec, r_min;
    logic [4:0]           r_hour;
    logic [2:0]           r_wday;
    logic [7:0]           r_year;
    logic [REM_W-1:0]     r_yday;
    logic [REM_W-1:0]     r_mrem;
    logic [MONTH_W-1:0]   r_mon;

    logic [5:0]           r_o_sec, r_o_min;
    logic [4:0]           r_o_hour;
    logic [2:0]           r_o_wday;
    logic [7:0]           r_o_year;
    logic [REM_W-1:0]     r_o_yday;
    logic [MONTH_W-1:0]   r_o_mon;
    logic [4:0]           r_o_dom;

    logic [W+CHUNK_W-1:0] partial;
    logic [W-1:0]         quot;
    logic [2*REM_W-1:0]   quot_by_div;
    logic [REM_W-1:0]     rem;
    logic [REM_W-1:0]     divisor;
    logic [W-1:0]         load_src;
    logic [REM_W-1:0]     cur_len;

    assign partial     = {{CHUNK_W{1'b0}}, r_q}
                       * {{W{1'b0}}, r_recip[RECIP_PAD-1 -: CHUNK_W]};
    assign quot        = r_acc[SHIFT +: W];
    assign divisor     = divisor_of(i_cmd.cur_sel);
    assign quot_by_div = {{REM_W{1'b0}}, quot[REM_W-1:0]} * {{REM_W{1'b0}}, divisor};
    assign rem         = r_q[REM_W-1:0] - quot_by_div[REM_W-1:0];
    assign cur_len     = {{(REM_W-5){1'b0}}, month_len(r_mon)};

    always_comb begin
        case (i_cmd.load_sel)
            DIV_SEC:  load_src = i_epoch_seconds;
            DIV_WDAY: load_src = quot + W'(4);
            DIV_YEAR: load_src = r_days;
            default:  load_src = quot;
        endcase
    end

    assign o_status.div_last   = (r_cnt == CNT_W'(NCHUNK - 1));
    assign o_status.month_done = (r_mon == MONTH_LAST) || (r_mrem < cur_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_q     <= load_src;
            r_recip <= recip_of(i_cmd.load_sel);
            r_acc   <= '0;
        end else if (i_cmd.step) begin
            r_recip <= {r_recip[RECIP_PAD-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
            r_acc   <= {r_acc[PROD_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}}
                     + {{(PROD_W-W-CHUNK_W){1'b0}}, partial};
        end

        if (i_cmd.capture) begin
            case (i_cmd.cur_sel)
                DIV_SEC: begin
                    r_sec <= rem[5:0];
                end
                DIV_MIN: begin
                    r_min <= rem[5:0];
                end
                DIV_HOUR: begin
                    r_hour <= rem[4:0];
                    r_days <= quot;
                end
                DIV_WDAY: begin
                    r_wday <= rem[2:0];
                end
                DIV_YEAR: begin
                    r_year <= quot[7:0] + YEAR_BASE;
                    r_yday <= rem;
                    r_mrem <= rem;
                    r_mon  <= '0;
                end
                default: begin
                    r_sec <= r_sec;
                end
            endcase
        end else if (i_cmd.month_step) begin
            r_mrem <= r_mrem - cur_len;
            r_mon  <= r_mon + MONTH_W'(1);
        end

        if (i_cmd.publish) begin
            r_o_sec  <= r_sec;
            r_o_min  <= r_min;
            r_o_hour <= r_hour;
            r_o_wday <= r_wday;
            r_o_year <= r_year;
            r_o_yday <= r_yday;
            r_o_mon  <= r_mon;
            r_o_dom  <= r_mrem[4:0] + 5'd1;
        end
    end

    assign o_second         = r_o_sec;
    assign o_minute         = r_o_min;
    assign o_hour           = r_o_hour;
    assign o_weekday        = r_o_wday;
    assign o_year_from_1900 = r_o_year;
    assign o_day_of_year    = r_o_yday;
    assign o_month          = r_o_mon;
    assign o_day_of_month   = r_o_dom;

endmodule

>>> rtl/seconds_to_calendar_fields_top.sv
// Converts a count of seconds since the start of 1970 into calendar fields under a
// calendar of 365-day years with a 28-day February. One shared divider works by
// reciprocal multiplication: the dividend is multiplied by a scaled reciprocal of the
// divisor, sixteen bits of the reciprocal per cycle, and the remainder is recovered
// from the quotient. It is run five times in turn (by 60, 60, 24, 7 and 365), each run
// working through all N = ceil((SECONDS_WIDTH + 9) / 16) reciprocal slices; the month
// is then found by subtracting month lengths, one month per cycle, stopping at December
// at the latest. One item is worked on at a time; the result sits in an output register,
// so the next input transfer is taken while a finished result still waits.
module seconds_to_calendar_fields_top
    import stcf_pkg::*;
#(
    parameter int unsigned SECONDS_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stcf_in_if.sink    i_in,
    stcf_out_if.source o_out
);

    t_dp_cmd    cmd;
    t_dp_status status;

    stcf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    stcf_datapath #(
        .SECONDS_WIDTH (SECONDS_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_epoch_seconds  (i_in.epoch_seconds),
        .o_second         (o_out.second),
        .o_minute         (o_out.minute),
        .o_hour           (o_out.hour),
        .o_weekday        (o_out.weekday),
        .o_year_from_1900 (o_out.year_from_1900),
        .o_day_of_year    (o_out.day_of_year),
        .o_month          (o_out.month),
        .o_day_of_month   (o_out.day_of_month)
    );

endmodule
